// ===== hdl/bmprle_pkg.sv =====
// Shared types and constants of the BMP RLE8/RLE4 span decoder.
package bmprle_pkg;

  // Default width of the column and line counters.
  localparam int unsigned CoordBitsDef = 16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FOUR_BIT = 2'd0;
  localparam logic [1:0] CFG_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_HEIGHT   = 2'd2;
  localparam logic [1:0] CFG_FLIP     = 2'd3;

  // Escape codes that follow a zero control byte.
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic [7:0] NIB_MASK = 8'h0F;

  // Operations handed from the parser to the span unit.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SPAN,
    OP_EOL,
    OP_EOB,
    OP_DELTA
  } op_e;

  // One queued command. For OP_DELTA, len carries the column step.
  typedef struct packed {
    op_e        op;
    logic       clear;
    logic [7:0] len;
    logic [7:0] pix_a;
    logic [7:0] pix_b;
    logic [7:0] dy;
  } cmd_t;

endpackage

// ===== hdl/bmprle_front.sv =====
// Byte parser: tracks the RLE phase and turns bytes into span-unit commands.
module bmprle_front
  import bmprle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       four_bit_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_start_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    PH_CTRL,
    PH_RUNVAL,
    PH_ESC,
    PH_DX,
    PH_DY,
    PH_LIT,
    PH_PAD,
    PH_DONE
  } phase_e;

  phase_e     phase_q, phase_d, phase_cur;
  logic [7:0] run_q, run_d;
  logic [7:0] dx_q, dx_d;
  logic [7:0] left_q, left_d;
  logic       pad_q, pad_d;
  logic [7:0] hi, lo, n;
  logic [8:0] bytes_rle4;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign hi = four_bit_i ? {4'b0000, data_byte_i[7:4]} : data_byte_i;
  assign lo = four_bit_i ? (data_byte_i & NIB_MASK) : data_byte_i;
  assign bytes_rle4 = ({1'b0, data_byte_i} + 9'd1) >> 1;

  always_comb begin
    phase_cur = frame_start_i ? PH_CTRL : phase_q;
    phase_d   = phase_cur;
    run_d     = run_q;
    dx_d      = dx_q;
    left_d    = left_q;
    pad_d     = pad_q;
    n         = 8'd0;
    cmd_o       = '0;
    cmd_o.op    = OP_NONE;
    cmd_o.clear = frame_start_i;
    case (phase_cur)
      PH_CTRL: begin
        if (data_byte_i != 8'd0) begin
          run_d   = data_byte_i;
          phase_d = PH_RUNVAL;
        end else begin
          phase_d = PH_ESC;
        end
      end
      PH_RUNVAL: begin
        cmd_o.op    = OP_SPAN;
        cmd_o.len   = run_q;
        cmd_o.pix_a = hi;
        cmd_o.pix_b = lo;
        phase_d     = PH_CTRL;
      end
      PH_ESC: begin
        case (data_byte_i)
          ESC_EOL: begin
            cmd_o.op = OP_EOL;
            phase_d  = PH_CTRL;
          end
          ESC_EOB: begin
            cmd_o.op = OP_EOB;
            phase_d  = PH_DONE;
          end
          ESC_DELTA: phase_d = PH_DX;
          default: begin
            // Absolute literal; a pad byte follows an odd count of data bytes.
            left_d  = data_byte_i;
            pad_d   = four_bit_i ? bytes_rle4[0] : data_byte_i[0];
            phase_d = PH_LIT;
          end
        endcase
      end
      PH_DX: begin
        dx_d    = data_byte_i;
        phase_d = PH_DY;
      end
      PH_DY: begin
        cmd_o.op  = OP_DELTA;
        cmd_o.len = dx_q;
        cmd_o.dy  = data_byte_i;
        phase_d   = PH_CTRL;
      end
      PH_LIT: begin
        if (four_bit_i) begin
          n           = (left_q >= 8'd2) ? 8'd2 : left_q;
          cmd_o.pix_a = hi;
          cmd_o.pix_b = (n == 8'd2) ? lo : 8'd0;
        end else begin
          n           = (left_q >= 8'd1) ? 8'd1 : left_q;
          cmd_o.pix_a = data_byte_i;
          cmd_o.pix_b = data_byte_i;
        end
        cmd_o.op  = OP_SPAN;
        cmd_o.len = n;
        left_d    = left_q - n;
        if (left_d == 8'd0) begin
          phase_d = pad_q ? PH_PAD : PH_CTRL;
        end
      end
      PH_PAD: begin
        pad_d   = 1'b0;
        phase_d = PH_CTRL;
      end
      PH_DONE: phase_d = PH_DONE;
      default: phase_d = PH_CTRL;
    endcase
  end

  assign push_o = accept && ((cmd_o.op != OP_NONE) || frame_start_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CTRL;
      run_q   <= 8'd0;
      dx_q    <= 8'd0;
      left_q  <= 8'd0;
      pad_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      run_q   <= run_d;
      dx_q    <= dx_d;
      left_q  <= left_d;
      pad_q   <= pad_d;
    end
  end

endmodule

// ===== hdl/bmprle_queue.sv =====
// Two-entry command queue between the parser and the span unit.
module bmprle_queue
  import bmprle_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hdl/bmprle_back.sv =====
// Span unit: owns the column and line counters, clips spans and drives results.
module bmprle_back
  import bmprle_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] width_i,
  input  logic [15:0] height_i,
  input  logic        flip_i,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] x_start_o,
  output logic [15:0] row_o,
  output logic [7:0]  span_length_o,
  output logic [7:0]  first_pixel_o,
  output logic [7:0]  second_pixel_o,
  output logic        end_of_image_o
);

  localparam int unsigned CW = (COORD_BITS > 16) ? COORD_BITS : 16;

  function automatic logic [COORD_BITS-1:0] sat_add(logic [COORD_BITS-1:0] a,
                                                    logic [7:0] b);
    logic [COORD_BITS:0] s;
    s = {1'b0, a} + (COORD_BITS+1)'(b);
    return s[COORD_BITS] ? {COORD_BITS{1'b1}} : s[COORD_BITS-1:0];
  endfunction

  logic [COORD_BITS-1:0] col_q, col_d, col_cur;
  logic [COORD_BITS-1:0] line_q, line_d, line_cur;
  logic [CW-1:0]         col_w, line_w, w_w, h_w, avail, row_w;
  logic [7:0]            len_clip;
  logic                  emit, in_image;
  logic                  out_valid_q;
  logic [15:0]           x_q, row_q;
  logic [7:0]            len_q, pa_q, pb_q;
  logic                  eoi_q;

  assign pop_o = cmd_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    col_cur  = cmd_i.clear ? '0 : col_q;
    line_cur = cmd_i.clear ? '0 : line_q;
    col_w    = CW'(col_cur);
    line_w   = CW'(line_cur);
    w_w      = CW'(width_i);
    h_w      = CW'(height_i);
    avail    = w_w - col_w;
    in_image = (col_w < w_w) && (line_w < h_w);
    len_clip = (CW'(cmd_i.len) > avail) ? avail[7:0] : cmd_i.len;
    row_w    = flip_i ? (h_w - CW'(1) - line_w) : line_w;
    col_d    = col_cur;
    line_d   = line_cur;
    emit     = 1'b0;
    case (cmd_i.op)
      OP_SPAN: begin
        emit  = in_image;
        col_d = sat_add(col_cur, cmd_i.len);
      end
      OP_EOL: begin
        col_d  = '0;
        line_d = sat_add(line_cur, 8'd1);
      end
      OP_EOB: emit = 1'b1;
      OP_DELTA: begin
        col_d  = sat_add(col_cur, cmd_i.len);
        line_d = sat_add(line_cur, cmd_i.dy);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      line_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result takes the register in the same cycle the old one leaves.
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        col_q  <= col_d;
        line_q <= line_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      if (cmd_i.op == OP_EOB) begin
        x_q   <= 16'd0;
        row_q <= 16'd0;
        len_q <= 8'd0;
        pa_q  <= 8'd0;
        pb_q  <= 8'd0;
        eoi_q <= 1'b1;
      end else begin
        x_q   <= col_w[15:0];
        row_q <= row_w[15:0];
        len_q <= len_clip;
        pa_q  <= cmd_i.pix_a;
        pb_q  <= cmd_i.pix_b;
        eoi_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign x_start_o      = x_q;
  assign row_o          = row_q;
  assign span_length_o  = len_q;
  assign first_pixel_o  = pa_q;
  assign second_pixel_o = pb_q;
  assign end_of_image_o = eoi_q;

endmodule

// ===== hdl/bmp_rle_decoder.sv =====
// Top level of the BMP RLE8/RLE4 span decoder.
//
// The decoder takes one compressed byte per item on the input channel
// (data_byte_i with frame_start_i, valid/ready) and gives at most one span
// per byte on the output channel: start column, output row, length and the
// two alternating pixel values, or an end-of-image marker.
// A parser accepts bytes and tracks the RLE phase; it hands commands through
// a two-entry queue to a span unit that owns the column and line counters,
// clips spans and holds the result register. One byte is accepted per cycle
// while the queue has room, one command is retired per cycle while the result
// register is free or read, so without stalls the rate is one item per cycle;
// a span goes through a queue entry and then the result register. When the
// receiver stalls, the result register holds its span, the queue fills and
// input ready drops once both queue entries are in use. Reset clears the
// parse phase, the counters, the queue and the result valid, and sets all
// configuration registers to zero. frame_start_i on a byte restarts the image
// before that byte is decoded. The user must write configuration via cfg_we_i,
// cfg_index_i and cfg_data_i only while idle; the block does not enforce this.
module bmp_rle_decoder
  import bmprle_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] x_start_o,
  output logic [15:0] row_o,
  output logic [7:0]  span_length_o,
  output logic [7:0]  first_pixel_o,
  output logic [7:0]  second_pixel_o,
  output logic        end_of_image_o
);

  logic        four_bit_q;
  logic [15:0] width_q, height_q;
  logic        flip_q;

  logic push, q_full, q_valid, pop;
  cmd_t cmd_in, cmd_out;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_bit_q <= 1'b0;
      width_q    <= 16'd0;
      height_q   <= 16'd0;
      flip_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FOUR_BIT: four_bit_q <= cfg_data_i[0];
        CFG_WIDTH:    width_q    <= cfg_data_i;
        CFG_HEIGHT:   height_q   <= cfg_data_i;
        CFG_FLIP:     flip_q     <= cfg_data_i[0];
        default:      flip_q     <= flip_q;
      endcase
    end
  end

  // Parser: one byte per cycle whenever the queue has room.
  bmprle_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .four_bit_i    (four_bit_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  // Decouples the parser from stalls on the output side.
  bmprle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (cmd_out)
  );

  // Span unit: counters, clipping, optional row flip and the result register.
  bmprle_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .width_i        (width_q),
    .height_i       (height_q),
    .flip_i         (flip_q),
    .cmd_valid_i    (q_valid),
    .cmd_i          (cmd_out),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .x_start_o      (x_start_o),
    .row_o          (row_o),
    .span_length_o  (span_length_o),
    .first_pixel_o  (first_pixel_o),
    .second_pixel_o (second_pixel_o),
    .end_of_image_o (end_of_image_o)
  );

endmodule
